[sv/tsc_pkg.sv]
`default_nettype none
package tsc_pkg;

  // Longest terminator that can be stored
  localparam int MaxTerm = 32;
  localparam int TermAw  = (MaxTerm > 1) ? $clog2(MaxTerm) : 1;
  localparam int LenW    = $clog2(MaxTerm + 1);

  localparam logic [LenW-1:0] LEN_FULL = LenW'(MaxTerm);

  // Operation codes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  // Result kinds
  localparam logic KIND_BODY   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Scan status codes
  localparam logic [1:0] STS_NO_TERM   = 2'd0;
  localparam logic [1:0] STS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STS_FOUND     = 2'd2;
  localparam logic [1:0] STS_OVERFLOW  = 2'd3;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_NL    = 8'h0a;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] byte_in;
  } in_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  body_byte;
    logic [1:0]  status;
    logic [31:0] line_number;
    logic        last;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic       cap;        // input transfer, capture item
    logic       active;     // a scan is open at capture
    logic       clr_scan;   // empty terminator, match position zero
    logic       wr_term;    // append captured byte to terminator
    logic       pos_inc;
    logic       pos_one;
    logic       pos_clr;
    logic       fidx_clr;
    logic       fidx_inc;
    logic       rd_fidx;    // address store by flush index
    logic       emit;       // load output register
    logic       kind;
    logic [1:0] status;
    logic       src_rd;     // body byte from store read data
    logic       last;
  } tsc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       gt_space;
    logic       len_full;
    logic       len_zero;
    logic       match;
    logic       pos_zero;
    logic       pos_done;   // one more match completes the terminator
    logic       fidx_last;
    logic       eq_first;
    logic       out_free;
  } tsc_sts_t;

endpackage
`default_nettype wire

[sv/terminated_string_collector.sv]
`default_nettype none
// Scans a byte stream for a string literal closed by a terminator of the
// user's choice. A start item opens a scan; the bytes above space that follow
// form the terminator (up to 32 bytes), and the first byte at or below space
// opens the body if the terminator is not empty. Body bytes come out one per
// result, and the scan closes with a status result (found, not found, no
// terminator, overflow); the last result of each item carries last. An item
// is taken in S_ACCEPT and decided in S_EXEC against the terminator byte read
// from the store as it was taken. A mismatch after a partial match re-emits
// each prefix byte via read and output states (one store read port,
// registered), then a closing state. Output stalls hold the item in progress.
module terminated_string_collector (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_stall_o,
  input  tsc_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  wire            out_stall_i,
  output tsc_pkg::out_t  out_data_o
);
  import tsc_pkg::*;

  tsc_cmd_t cmd;
  tsc_sts_t sts;

  tsc_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tsc_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

[sv/tsc_datapath.sv]
`default_nettype none
module tsc_datapath (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  tsc_pkg::in_t       in_data_i,
  input  tsc_pkg::tsc_cmd_t  cmd_i,
  output tsc_pkg::tsc_sts_t  sts_o,
  input  wire                out_stall_i,
  output logic               out_valid_o,
  output tsc_pkg::out_t      out_data_o
);
  import tsc_pkg::*;

  logic [7:0]        term_mem [MaxTerm];
  logic [7:0]        rd_q;
  logic [TermAw-1:0] rd_addr;
  logic [7:0]        first_q;
  logic [1:0]        op_q;
  logic [7:0]        byte_q;
  logic [LenW-1:0]   len_q, len_d;
  logic [LenW-1:0]   pos_q, pos_d;
  logic [LenW-1:0]   fidx_q, fidx_d;
  logic [31:0]       line_q, line_d;
  logic              out_valid_q;
  out_t              out_q;
  logic              in_nl;

  assign rd_addr = cmd_i.rd_fidx ? fidx_q[TermAw-1:0] : pos_q[TermAw-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_term) begin
      term_mem[len_q[TermAw-1:0]] <= byte_q;
    end
    rd_q <= term_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      op_q   <= in_data_i.operation;
      byte_q <= in_data_i.byte_in;
    end
    if (cmd_i.wr_term && len_q == '0) begin
      first_q <= byte_q;
    end
  end

  assign in_nl = cmd_i.cap && cmd_i.active && in_data_i.operation == OP_BYTE
                 && in_data_i.byte_in == CHAR_NL;

  always_comb begin
    len_d  = len_q;
    pos_d  = pos_q;
    fidx_d = fidx_q;
    line_d = line_q;
    if (cmd_i.clr_scan) begin
      len_d = '0;
    end else if (cmd_i.wr_term) begin
      len_d = len_q + LenW'(1);
    end
    priority if (cmd_i.clr_scan || cmd_i.pos_clr) begin
      pos_d = '0;
    end else if (cmd_i.pos_one) begin
      pos_d = LenW'(1);
    end else if (cmd_i.pos_inc) begin
      pos_d = pos_q + LenW'(1);
    end else begin
      pos_d = pos_q;
    end
    if (cmd_i.fidx_clr) begin
      fidx_d = '0;
    end else if (cmd_i.fidx_inc) begin
      fidx_d = fidx_q + LenW'(1);
    end
    if (in_nl) begin
      line_d = line_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      pos_q  <= '0;
      fidx_q <= '0;
      line_q <= 32'd1;
    end else begin
      len_q  <= len_d;
      pos_q  <= pos_d;
      fidx_q <= fidx_d;
      line_q <= line_d;
    end
  end

  // Output register: load a result when empty or being drained
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.kind        <= cmd_i.kind;
      out_q.body_byte   <= (cmd_i.kind == KIND_STATUS) ? 8'd0 :
                           (cmd_i.src_rd ? rd_q : byte_q);
      out_q.status      <= (cmd_i.kind == KIND_STATUS) ? cmd_i.status : 2'd0;
      out_q.line_number <= line_q;
      out_q.last        <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    sts_o.op        = op_q;
    sts_o.gt_space  = byte_q > CHAR_SPACE;
    sts_o.len_full  = len_q >= LEN_FULL;
    sts_o.len_zero  = len_q == '0;
    sts_o.match     = (pos_q < len_q) && (byte_q == rd_q);
    sts_o.pos_zero  = pos_q == '0;
    sts_o.pos_done  = (pos_q + LenW'(1)) >= len_q;
    sts_o.fidx_last = (fidx_q + LenW'(1)) == pos_q;
    sts_o.eq_first  = byte_q == first_q;
    sts_o.out_free  = !out_valid_q || !out_stall_i;
  end

endmodule
`default_nettype wire

[sv/tsc_controller.sv]
`default_nettype none
module tsc_controller (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  tsc_pkg::tsc_sts_t  sts_i,
  output tsc_pkg::tsc_cmd_t  cmd_o
);
  import tsc_pkg::*;

  localparam logic [2:0] S_ACCEPT = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_FL_RD  = 3'd2;
  localparam logic [2:0] S_FL_OUT = 3'd3;
  localparam logic [2:0] S_POST   = 3'd4;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_TERM = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  logic [2:0] state_q, state_d;
  logic [1:0] phase_q, phase_d;

  assign in_stall_o = state_q != S_ACCEPT;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    phase_d = phase_q;
    unique case (state_q)
      S_ACCEPT: begin
        cmd_o.cap    = in_valid_i;
        cmd_o.active = phase_q != PH_IDLE;
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        priority if (sts_i.op == OP_START) begin
          cmd_o.clr_scan = 1'b1;
          phase_d        = PH_TERM;
          state_d        = S_ACCEPT;
        end else if (phase_q == PH_IDLE) begin
          state_d = S_ACCEPT;
        end else if (sts_i.op == OP_BYTE && phase_q == PH_TERM) begin
          if (sts_i.gt_space && !sts_i.len_full) begin
            cmd_o.wr_term = 1'b1;
            state_d       = S_ACCEPT;
          end else if (!sts_i.gt_space && !sts_i.len_zero) begin
            cmd_o.pos_clr = 1'b1;
            phase_d       = PH_BODY;
            state_d       = S_ACCEPT;
          end else if (sts_i.out_free) begin
            cmd_o.emit   = 1'b1;
            cmd_o.kind   = KIND_STATUS;
            cmd_o.status = sts_i.gt_space ? STS_OVERFLOW : STS_FOUND;
            cmd_o.last   = 1'b1;
            phase_d      = PH_IDLE;
            state_d      = S_ACCEPT;
          end
        end else if (sts_i.op == OP_BYTE) begin
          if (sts_i.match && !sts_i.pos_done) begin
            cmd_o.pos_inc = 1'b1;
            state_d       = S_ACCEPT;
          end else if (!sts_i.match && !sts_i.pos_zero) begin
            cmd_o.fidx_clr = 1'b1;
            state_d        = S_FL_RD;
          end else if (sts_i.out_free) begin
            // Complete match or plain body byte
            cmd_o.emit   = 1'b1;
            cmd_o.kind   = sts_i.match ? KIND_STATUS : KIND_BODY;
            cmd_o.status = STS_FOUND;
            cmd_o.last   = 1'b1;
            if (sts_i.match) begin
              cmd_o.pos_clr = 1'b1;
              phase_d       = PH_IDLE;
            end
            state_d = S_ACCEPT;
          end
        end else if (sts_i.op == OP_END) begin
          if (phase_q == PH_BODY && !sts_i.pos_zero) begin
            cmd_o.fidx_clr = 1'b1;
            state_d        = S_FL_RD;
          end else if (sts_i.out_free) begin
            cmd_o.emit   = 1'b1;
            cmd_o.kind   = KIND_STATUS;
            cmd_o.status = (phase_q == PH_TERM) ? STS_NO_TERM : STS_NOT_FOUND;
            cmd_o.last   = 1'b1;
            phase_d      = PH_IDLE;
            state_d      = S_ACCEPT;
          end
        end else begin
          state_d = S_ACCEPT;
        end
      end
      S_FL_RD: begin
        cmd_o.rd_fidx = 1'b1;
        state_d       = S_FL_OUT;
      end
      S_FL_OUT: begin
        cmd_o.rd_fidx = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.kind     = KIND_BODY;
          cmd_o.src_rd   = 1'b1;
          // Prefix closes the item when the byte restarts a match
          cmd_o.last     = sts_i.fidx_last && sts_i.op == OP_BYTE && sts_i.eq_first;
          cmd_o.fidx_inc = 1'b1;
          state_d        = sts_i.fidx_last ? S_POST : S_FL_RD;
        end
      end
      S_POST: begin
        if (sts_i.op == OP_BYTE && sts_i.eq_first) begin
          cmd_o.pos_one = 1'b1;
          state_d       = S_ACCEPT;
        end else if (sts_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.kind    = (sts_i.op == OP_END) ? KIND_STATUS : KIND_BODY;
          cmd_o.status  = STS_NOT_FOUND;
          cmd_o.last    = 1'b1;
          cmd_o.pos_clr = 1'b1;
          if (sts_i.op == OP_END) begin
            phase_d = PH_IDLE;
          end
          state_d = S_ACCEPT;
        end
      end
      default: begin
        state_d = S_ACCEPT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_ACCEPT;
      phase_q <= PH_IDLE;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

endmodule
`default_nettype wire

[sv/tsc_checker.sv]
`default_nettype none
module tsc_checker (
  input wire            clk_i,
  input wire            rst_ni,
  input wire            in_valid_i,
  input wire            in_stall_o,
  input wire            out_valid_o,
  input wire            out_stall_i,
  input tsc_pkg::out_t  out_data_o
);
  import tsc_pkg::*;

  // Taking an item raises the input stall, so no two items are taken back to back
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken on consecutive cycles");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_STATUS |-> out_data_o.last)
    else $error("status result not marked last");

  a_field_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.kind == KIND_STATUS) ? (out_data_o.body_byte == 8'd0)
                                                     : (out_data_o.status == 2'd0))
    else $error("unused result field not zero");

endmodule

bind terminated_string_collector tsc_checker u_tsc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
module testbench;
  import tsc_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;  // operation code with no meaning
  localparam int TOTAL_ITEMS = 170;
  localparam int TAIL_CYCLES = 4 * MaxTerm + 20;
  localparam int MAX_REPORTS = 10;

  typedef enum logic [1:0] {SCAN_IDLE, SCAN_TERM, SCAN_BODY} scan_phase_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  // Scanner state as the block should hold it
  scan_phase_e scan_phase = SCAN_IDLE;
  logic [7:0] term_bytes [MaxTerm];
  int term_len = 0;
  int match_pos = 0;
  logic [31:0] line_cnt = 32'd1;

  out_t pending_results [$];
  int step_results;
  int items_used = 0;
  int err_cnt = 0;
  bit idle_on = 1'b1;
  int rx_hold = 0;
  int rx_draw;
  out_t want;
  logic out_take = 1'b0;
  out_t out_seen;

  terminated_string_collector i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic void push_result(logic kind, logic [7:0] b, logic [1:0] st);
    out_t res;
    res.kind = kind;
    res.body_byte = b;
    res.status = st;
    res.line_number = line_cnt;
    res.last = 1'b0;
    pending_results.push_back(res);
    step_results++;
  endfunction

  // Re-emit the matched terminator prefix as body bytes
  function automatic void flush_match();
    for (int i = 0; i < match_pos; i++) push_result(KIND_BODY, term_bytes[i], STS_NO_TERM);
    match_pos = 0;
  endfunction

  function automatic void predict_scan_step(logic [1:0] op, logic [7:0] b);
    out_t tail;
    step_results = 0;
    if (op == OP_START) begin
      scan_phase = SCAN_TERM;
      term_len = 0;
      match_pos = 0;
    end else if (scan_phase != SCAN_IDLE && op == OP_BYTE) begin
      if (b == CHAR_NL) line_cnt = line_cnt + 32'd1;
      if (scan_phase == SCAN_TERM) begin
        if (b > CHAR_SPACE) begin
          if (term_len >= MaxTerm) begin
            push_result(KIND_STATUS, 8'h00, STS_OVERFLOW);
            scan_phase = SCAN_IDLE;
          end else begin
            term_bytes[term_len] = b;
            term_len++;
          end
        end else if (term_len == 0) begin
          push_result(KIND_STATUS, 8'h00, STS_FOUND);
          scan_phase = SCAN_IDLE;
        end else begin
          scan_phase = SCAN_BODY;
          match_pos = 0;
        end
      end else begin
        if (match_pos < term_len && b == term_bytes[match_pos]) begin
          match_pos++;
        end else begin
          // naive restart: test the same byte again from position zero
          flush_match();
          if (b == term_bytes[0]) match_pos = 1;
          else push_result(KIND_BODY, b, STS_NO_TERM);
        end
        if (match_pos >= term_len) begin
          push_result(KIND_STATUS, 8'h00, STS_FOUND);
          scan_phase = SCAN_IDLE;
          match_pos = 0;
        end
      end
    end else if (scan_phase != SCAN_IDLE && op == OP_END) begin
      if (scan_phase == SCAN_TERM) begin
        push_result(KIND_STATUS, 8'h00, STS_NO_TERM);
      end else begin
        flush_match();
        push_result(KIND_STATUS, 8'h00, STS_NOT_FOUND);
      end
      scan_phase = SCAN_IDLE;
    end
    if (step_results > 0) begin
      tail = pending_results.pop_back();
      tail.last = 1'b1;
      pending_results.push_back(tail);
    end
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [7:0] b);
    int gap;
    logic stalled;
    gap = idle_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{operation: op, byte_in: b};
    // sample stall between edges, then take the transfer at the next edge
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    items_used++;
    predict_scan_step(op, b);
  endtask

  // Hold off the sender until every expected result is out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] letter_ab();
    return 8'h61 + 8'($urandom_range(0, 1));
  endfunction

  // Sample the output side between edges so the next edge sees settled values
  always @(negedge clk_i) begin
    out_take = rst_ni && out_valid_o && !out_stall_i;
    out_seen = out_data_o;
  end

  // Receiver: draw a stall length after every transfer
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_hold <= 0;
    end else if (out_take) begin
      rx_draw = idle_on ? $urandom_range(0, 19) : 0;
      rx_hold <= rx_draw;
      out_stall_i <= (rx_draw != 0);
    end else if (rx_hold > 1) begin
      rx_hold <= rx_hold - 1;
    end else begin
      rx_hold <= 0;
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (out_take) begin
      if (pending_results.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("unexpected result: kind=%0d byte=%02h status=%0d line=%0d last=%0d",
                   out_seen.kind, out_seen.body_byte, out_seen.status,
                   out_seen.line_number, out_seen.last);
      end else begin
        want = pending_results.pop_front();
        if (out_seen.kind !== want.kind || out_seen.body_byte !== want.body_byte ||
            out_seen.status !== want.status ||
            out_seen.line_number !== want.line_number || out_seen.last !== want.last)
        begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS) begin
            $display("mismatch: exp kind=%0d byte=%02h status=%0d line=%0d last=%0d,",
                     want.kind, want.body_byte, want.status, want.line_number, want.last);
            $display("          got kind=%0d byte=%02h status=%0d line=%0d last=%0d",
                     out_seen.kind, out_seen.body_byte, out_seen.status,
                     out_seen.line_number, out_seen.last);
          end
        end
      end
    end
  end

  task automatic test_empty_terminator();
    send_item(OP_START, 8'h00);
    send_item(OP_BYTE, CHAR_SPACE);
    send_item(OP_START, 8'hff);
    send_item(OP_BYTE, CHAR_NL);
  endtask

  task automatic test_idle_and_unused();
    send_item(OP_BYTE, 8'h78);
    send_item(OP_BYTE, CHAR_NL);
    send_item(OP_END, 8'h00);
    send_item(OP_UNUSED, 8'hff);
    send_item(OP_START, 8'h00);
    send_item(OP_UNUSED, 8'h55);
    send_item(OP_BYTE, 8'h71);
    send_item(OP_END, 8'hff);
  endtask

  task automatic test_found();
    send_item(OP_START, 8'h00);
    send_item(OP_BYTE, 8'hff);
    send_item(OP_BYTE, 8'h21);
    send_item(OP_BYTE, CHAR_NL);
    send_item(OP_BYTE, 8'h41);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hff);
    send_item(OP_BYTE, 8'h21);
  endtask

  // Terminator "aab" against body "aaaba": the restart misses the match
  task automatic test_naive_restart();
    send_item(OP_START, 8'h00);
    send_item(OP_BYTE, 8'h61);
    send_item(OP_BYTE, 8'h61);
    send_item(OP_BYTE, 8'h62);
    send_item(OP_BYTE, CHAR_SPACE);
    send_item(OP_BYTE, 8'h61);
    send_item(OP_BYTE, 8'h61);
    send_item(OP_BYTE, 8'h61);
    send_item(OP_BYTE, 8'h62);
    send_item(OP_BYTE, 8'h61);
    send_item(OP_END, 8'h00);
  endtask

  task automatic test_abandoned_scan();
    send_item(OP_START, 8'h00);
    send_item(OP_BYTE, 8'h78);
    send_item(OP_START, 8'h00);
    send_item(OP_BYTE, 8'h79);
    send_item(OP_BYTE, CHAR_SPACE);
    send_item(OP_BYTE, 8'h79);
  endtask

  task automatic test_long_terminator();
    logic [7:0] seq [MaxTerm];
    foreach (seq[i]) seq[i] = 8'($urandom_range(8'h21, 8'hff));
    // full-length terminator matched to its last byte
    send_item(OP_START, 8'h00);
    foreach (seq[i]) send_item(OP_BYTE, seq[i]);
    send_item(OP_BYTE, CHAR_SPACE);
    foreach (seq[i]) send_item(OP_BYTE, seq[i]);
    // one byte past the store
    send_item(OP_START, 8'h00);
    foreach (seq[i]) send_item(OP_BYTE, seq[i]);
    send_item(OP_BYTE, 8'h7e);
  endtask

  task automatic test_random_scans();
    logic [7:0] term_seq [$];
    logic [7:0] b;
    int r;
    int tlen;
    int blen;
    while (items_used < TOTAL_ITEMS) begin
      idle_on = ($urandom_range(0, 4) != 0);
      term_seq.delete();
      send_item(OP_START, 8'($urandom));
      r = $urandom_range(0, 19);
      tlen = (r == 0) ? 0 : (r == 1) ? $urandom_range(5, 12) : $urandom_range(1, 4);
      for (int i = 0; i < tlen; i++)
        term_seq.push_back(($urandom_range(0, 9) < 7) ? letter_ab() :
                           8'($urandom_range(8'h21, 8'hff)));
      foreach (term_seq[i]) send_item(OP_BYTE, term_seq[i]);
      r = $urandom_range(0, 19);
      if (r == 0) send_item(OP_END, 8'($urandom));
      else if (r == 1) send_item(OP_UNUSED, 8'($urandom));
      if (scan_phase == SCAN_TERM) send_item(OP_BYTE, 8'($urandom_range(0, 32)));
      blen = $urandom_range(0, 12);
      for (int i = 0; i < blen && scan_phase == SCAN_BODY; i++) begin
        r = $urandom_range(0, 19);
        if (r < 8) b = letter_ab();
        else if (r < 11) b = CHAR_NL;
        else if (r < 14 && tlen > 0) b = term_seq[$urandom_range(0, tlen - 1)];
        else b = 8'($urandom);
        send_item(OP_BYTE, b);
      end
      r = $urandom_range(0, 9);
      if (r < 6) begin
        foreach (term_seq[i])
          if (scan_phase == SCAN_BODY) send_item(OP_BYTE, term_seq[i]);
      end else if (r < 8) begin
        send_item(OP_END, 8'($urandom));
      end
      // otherwise leave the scan open for the next start to drop
      if ($urandom_range(0, 4) == 0) send_item(OP_BYTE, 8'($urandom));
      if ($urandom_range(0, 5) == 0) wait_drained();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_terminator();
    test_idle_and_unused();
    wait_drained();
    test_found();
    test_naive_restart();
    test_abandoned_scan();
    wait_drained();
    test_long_terminator();
    wait_drained();
    test_random_scans();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("[terminated_string_collector] OK");
    end else begin
      $display("[terminated_string_collector] ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[terminated_string_collector] ERROR");
    $finish;
  end

endmodule
